/* rtl/lrf_pkg.sv */
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the linear regression fit block.
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int MAX_POINTS_DEFAULT = 1024;
   localparam int SAMPLE_W           = 32;
   localparam int R2_W               = 17;
   localparam int POINT_COUNT_W      = 11;
   localparam int STATUS_W           = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_SLOPE_ZERO  = 2'd1,
      ST_R2_ZERO     = 2'd2,
      ST_OVERFLOW    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACC_XY,
      OP_ACC_XX,
      OP_SET_T1,
      OP_SET_NUM,
      OP_SET_DEN,
      OP_SET_ORIGIN,
      OP_SET_SLOPE,
      OP_SET_ICPT,
      OP_SET_AVG,
      OP_PASS_INIT,
      OP_SET_YH,
      OP_ACC_A,
      OP_ACC_C,
      OP_SET_R2,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      MS_XY,
      MS_XX,
      MS_NSXY,
      MS_SXSY,
      MS_NSXX,
      MS_SXSX,
      MS_MSX,
      MS_MXI,
      MS_DD,
      MS_RR,
      MS_YHYH,
      MS_YIYI
   } mul_sel_type;

   typedef enum logic [1:0] {
      DS_SLOPE,
      DS_ICPT,
      DS_AVG,
      DS_R2
   } div_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      status_type  status;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic stored;
      logic last;
      logic ovf;
      logic through;
      logic den_zero;
      logic c_zero;
      logic pass_last;
   } dp_status_type;

endpackage

/* rtl/lrf_mul.sv */
// ----------------------------------------------------------------------------
// lrf_mul
// Iterative 64 x 64 signed multiplier, one 32 x 32 partial product a cycle.
// ----------------------------------------------------------------------------
module lrf_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic [127:0] product,
   output logic         done
);

   localparam logic [2:0] LAST_STEP = 3'd5;

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   step_ff;
   logic [63:0]  mag_a_ff;
   logic [63:0]  mag_b_ff;
   logic         neg_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pair_ff;
   logic [127:0] acc_ff;
   logic [127:0] prod_ff;

   logic [31:0]  part_a;
   logic [31:0]  part_b;
   logic [127:0] pp_shifted;

   always_comb begin
      part_a = step_ff[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      part_b = step_ff[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      case (pair_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd3:    pp_shifted = {pp_ff, 64'd0};
         default: pp_shifted = {32'd0, pp_ff, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_a_ff <= op_a[63] ? -op_a : op_a;
         mag_b_ff <= op_b[63] ? -op_b : op_b;
         neg_ff   <= op_a[63] ^ op_b[63];
         acc_ff   <= '0;
      end else if (busy_ff) begin
         if (step_ff < 3'd4) begin
            pp_ff   <= part_a * part_b;
            pair_ff <= step_ff[1:0];
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
            acc_ff <= acc_ff + pp_shifted;
         end
         if (step_ff == LAST_STEP) begin
            prod_ff <= neg_ff ? -acc_ff : acc_ff;
         end
      end
   end

   assign product = prod_ff;
   assign done    = done_ff;

endmodule

/* rtl/lrf_div.sv */
// ----------------------------------------------------------------------------
// lrf_div
// Iterative 128-bit signed divider, restoring, one quotient bit a cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module lrf_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [127:0] divisor,
   output logic [127:0] quotient,
   output logic         done
);

   localparam logic [7:0] STEPS = 8'd128;

   logic         busy_ff;
   logic         done_ff;
   logic [7:0]   cnt_ff;
   logic         neg_ff;
   logic [127:0] num_ff;
   logic [127:0] den_ff;
   logic [127:0] rem_ff;
   logic [127:0] quot_ff;

   logic [127:0] rem_sh;
   logic [128:0] diff;

   always_comb begin
      rem_sh = {rem_ff[126:0], num_ff[127]};
      diff   = {1'b0, rem_sh} - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 8'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 8'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 8'd1;
            if (cnt_ff == STEPS) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[127] ^ divisor[127];
         num_ff <= dividend[127] ? -dividend : dividend;
         den_ff <= divisor[127] ? -divisor : divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < STEPS) begin
            num_ff  <= {num_ff[126:0], 1'b0};
            quot_ff <= {quot_ff[126:0], ~diff[128]};
            rem_ff  <= diff[128] ? rem_sh : diff[127:0];
         end else begin
            quot_ff <= neg_ff ? -quot_ff : quot_ff;
         end
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

/* rtl/lrf_datapath.sv */
// ----------------------------------------------------------------------------
// lrf_datapath
// Point stores, running sums, fit registers and result registers; shares
// one multiplier and one divider under command of the controller.
// ----------------------------------------------------------------------------
module lrf_datapath #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrf_pkg::dp_cmd_type    cmd,
   output lrf_pkg::dp_status_type dp_status,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic signed [31:0]     req_x_sample,
   input  logic signed [31:0]     req_y_sample,
   input  logic                   req_last_point,
   output logic                   rsp_strobe,
   output logic signed [31:0]     rsp_intercept,
   output logic signed [31:0]     rsp_slope_value,
   output logic [16:0]            rsp_r_squared,
   output logic [10:0]            rsp_point_count,
   output logic [1:0]             rsp_status
);

   import lrf_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_POINTS);

   function automatic logic [63:0] sext32(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] sext48(logic [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic [127:0] sext64(logic [63:0] v);
      return {{64{v[63]}}, v};
   endfunction

   function automatic logic [31:0] sat32(logic [127:0] q);
      logic fits;
      fits = (&q[127:31]) | ~(|q[127:31]);
      if (fits) return q[31:0];
      return q[127] ? 32'h8000_0000 : 32'h7fff_ffff;
   endfunction

   function automatic logic [16:0] sat_r2(logic [127:0] q);
      if (q[127]) return 17'd0;
      if ((|q[126:17]) || (q[16] && (|q[15:0]))) return 17'h10000;
      return q[16:0];
   endfunction

   logic [31:0]   x_mem [MAX_POINTS];
   logic [31:0]   y_mem [MAX_POINTS];

   logic          through_ff;
   logic [CW-1:0] count_ff;
   logic [47:0]   sx_ff;
   logic [47:0]   sy_ff;
   logic [63:0]   sxy_ff;
   logic [63:0]   sxx_ff;
   logic          ovf_ff;
   logic [31:0]   xin_ff;
   logic [31:0]   yin_ff;
   logic          last_ff;
   logic          stored_ff;
   logic [127:0]  t1_ff;
   logic [127:0]  num_ff;
   logic [127:0]  den_ff;
   logic [31:0]   m_ff;
   logic [31:0]   b_ff;
   logic [63:0]   avg_ff;
   logic [63:0]   yh_ff;
   logic [CW-1:0] idx_ff;
   logic [31:0]   xrd_ff;
   logic [31:0]   yrd_ff;
   logic [127:0]  a_ff;
   logic [127:0]  c_ff;
   logic [16:0]   r2_ff;
   logic          strobe_ff;
   logic [31:0]   icpt_out_ff;
   logic [31:0]   slope_out_ff;
   logic [16:0]   r2_out_ff;
   logic [10:0]   cnt_out_ff;
   logic [1:0]    status_out_ff;

   logic          room;
   logic [63:0]   n64;
   logic [63:0]   d_val;
   logic [63:0]   r_val;
   logic [63:0]   mul_a;
   logic [63:0]   mul_b;
   logic [127:0]  prod;
   logic          mul_done;
   logic [127:0]  div_num;
   logic [127:0]  div_den;
   logic [127:0]  quot;
   logic          div_done;
   logic [64:0]   sum_xy_in;
   logic [64:0]   sum_xx_in;
   logic [127:0]  r2_top;
   logic [CW+10:0] cnt_wide;
   logic          fit_ok;

   always_comb begin
      room      = count_ff < CW'(MAX_POINTS);
      n64       = {{(64-CW){1'b0}}, count_ff};
      d_val     = sext32(yrd_ff) - avg_ff;
      r_val     = sext32(yrd_ff) - sext32(b_ff) - yh_ff;
      sum_xy_in = {sxy_ff[63], sxy_ff} + {prod[63], prod[63:0]};
      sum_xx_in = {sxx_ff[63], sxx_ff} + {prod[63], prod[63:0]};
      r2_top    = through_ff ? a_ff : (c_ff - a_ff);
      cnt_wide  = {11'd0, count_ff};
      fit_ok    = (cmd.status == ST_OK) || (cmd.status == ST_R2_ZERO);
   end

   always_comb begin
      case (cmd.mul_sel)
         MS_XY:   begin mul_a = sext32(xin_ff);  mul_b = sext32(yin_ff);  end
         MS_XX:   begin mul_a = sext32(xin_ff);  mul_b = sext32(xin_ff);  end
         MS_NSXY: begin mul_a = n64;             mul_b = sxy_ff;          end
         MS_SXSY: begin mul_a = sext48(sx_ff);   mul_b = sext48(sy_ff);   end
         MS_NSXX: begin mul_a = n64;             mul_b = sxx_ff;          end
         MS_SXSX: begin mul_a = sext48(sx_ff);   mul_b = sext48(sx_ff);   end
         MS_MSX:  begin mul_a = sext32(m_ff);    mul_b = sext48(sx_ff);   end
         MS_MXI:  begin mul_a = sext32(m_ff);    mul_b = sext32(xrd_ff);  end
         MS_DD:   begin mul_a = d_val;           mul_b = d_val;           end
         MS_RR:   begin mul_a = r_val;           mul_b = r_val;           end
         MS_YHYH: begin mul_a = yh_ff;           mul_b = yh_ff;           end
         MS_YIYI: begin mul_a = sext32(yrd_ff);  mul_b = sext32(yrd_ff);  end
         default: begin mul_a = '0;              mul_b = '0;              end
      endcase
   end

   always_comb begin
      case (cmd.div_sel)
         DS_SLOPE: begin
            div_num = {num_ff[111:0], 16'd0};
            div_den = den_ff;
         end
         DS_ICPT: begin
            div_num = {{64{sy_ff[47]}}, sy_ff, 16'd0} - t1_ff;
            div_den = {{(112-CW){1'b0}}, count_ff, 16'd0};
         end
         DS_AVG: begin
            div_num = sext64(sext48(sy_ff));
            div_den = {{(128-CW){1'b0}}, count_ff};
         end
         DS_R2: begin
            div_num = {r2_top[111:0], 16'd0};
            div_den = c_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   lrf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod),
      .done    (mul_done)
   );

   lrf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (quot),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && room) begin
         x_mem[count_ff[AW-1:0]] <= req_x_sample;
         y_mem[count_ff[AW-1:0]] <= req_y_sample;
      end
      xrd_ff <= x_mem[idx_ff[AW-1:0]];
      yrd_ff <= y_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         through_ff <= 1'b0;
         count_ff   <= '0;
         sx_ff      <= '0;
         sy_ff      <= '0;
         sxy_ff     <= '0;
         sxx_ff     <= '0;
         ovf_ff     <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_write_enable) begin
            through_ff <= csr_write_data;
         end
         case (cmd.op)
            OP_LOAD: begin
               if (room) begin
                  count_ff <= count_ff + CW'(1);
                  sx_ff    <= sx_ff + {{16{req_x_sample[31]}}, req_x_sample};
                  sy_ff    <= sy_ff + {{16{req_y_sample[31]}}, req_y_sample};
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            OP_ACC_XY: begin
               if (sum_xy_in[64] != sum_xy_in[63]) ovf_ff <= 1'b1;
               else sxy_ff <= sum_xy_in[63:0];
            end
            OP_ACC_XX: begin
               if (sum_xx_in[64] != sum_xx_in[63]) ovf_ff <= 1'b1;
               else sxx_ff <= sum_xx_in[63:0];
            end
            OP_EMIT: begin
               strobe_ff <= 1'b1;
               count_ff  <= '0;
               sx_ff     <= '0;
               sy_ff     <= '0;
               sxy_ff    <= '0;
               sxx_ff    <= '0;
               ovf_ff    <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            xin_ff    <= req_x_sample;
            yin_ff    <= req_y_sample;
            last_ff   <= req_last_point;
            stored_ff <= room;
         end
         OP_SET_T1:     t1_ff  <= prod;
         OP_SET_NUM:    num_ff <= t1_ff - prod;
         OP_SET_DEN:    den_ff <= t1_ff - prod;
         OP_SET_ORIGIN: begin
            num_ff <= sext64(sxy_ff);
            den_ff <= sext64(sxx_ff);
         end
         OP_SET_SLOPE:  m_ff   <= sat32(quot);
         OP_SET_ICPT:   b_ff   <= sat32(quot);
         OP_SET_AVG:    avg_ff <= quot[63:0];
         OP_PASS_INIT: begin
            idx_ff <= '0;
            a_ff   <= '0;
            c_ff   <= '0;
         end
         OP_SET_YH: begin
            yh_ff <= {{16{prod[63]}}, prod[63:16]} + {63'd0, prod[15]};
         end
         OP_ACC_A:      a_ff   <= a_ff + prod;
         OP_ACC_C: begin
            c_ff   <= c_ff + prod;
            idx_ff <= idx_ff + CW'(1);
         end
         OP_SET_R2:     r2_ff  <= sat_r2(quot);
         OP_EMIT: begin
            icpt_out_ff   <= (fit_ok && !through_ff) ? b_ff : 32'd0;
            slope_out_ff  <= fit_ok ? m_ff : 32'd0;
            r2_out_ff     <= (cmd.status == ST_OK) ? r2_ff : 17'd0;
            cnt_out_ff    <= cnt_wide[10:0];
            status_out_ff <= cmd.status;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      dp_status.mul_done  = mul_done;
      dp_status.div_done  = div_done;
      dp_status.stored    = stored_ff;
      dp_status.last      = last_ff;
      dp_status.ovf       = ovf_ff;
      dp_status.through   = through_ff;
      dp_status.den_zero  = (den_ff == '0);
      dp_status.c_zero    = (c_ff == '0);
      dp_status.pass_last = ((idx_ff + CW'(1)) == count_ff);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_intercept   = icpt_out_ff;
   assign rsp_slope_value = slope_out_ff;
   assign rsp_r_squared   = r2_out_ff;
   assign rsp_point_count = cnt_out_ff;
   assign rsp_status      = status_out_ff;

endmodule

/* rtl/lrf_ctrl.sv */
// ----------------------------------------------------------------------------
// lrf_ctrl
// Sequencer for point loading, the fit, the residual pass and the result.
// ----------------------------------------------------------------------------
module lrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lrf_pkg::dp_status_type dp_status,
   output lrf_pkg::dp_cmd_type    cmd
);

   import lrf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE, S_CHK, S_MXY, S_WXY, S_MXX, S_WXX,
      S_FIT, S_W1, S_M2, S_W2, S_M3, S_W3, S_M4, S_W4,
      S_DCHK, S_WDS, S_M5, S_W5, S_D2, S_WD2, S_D3, S_WD3,
      S_PINIT, S_PRD, S_PM, S_PW1, S_PM2, S_PW2, S_PM3, S_PW3,
      S_R2CHK, S_WD4, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff;
   status_type status_ff, status_in;

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      cmd.op        = OP_NONE;
      cmd.mul_start = 1'b0;
      cmd.mul_sel   = MS_XY;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DS_SLOPE;
      cmd.status    = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (dp_status.stored) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_XY;
               state_in      = S_WXY;
            end else begin
               state_in = dp_status.last ? S_FIT : S_IDLE;
            end
         end
         S_WXY: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_ACC_XY;
               state_in = S_MXX;
            end
         end
         S_MXX: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_XX;
            state_in      = S_WXX;
         end
         S_WXX: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_ACC_XX;
               state_in = dp_status.last ? S_FIT : S_IDLE;
            end
         end
         S_FIT: begin
            if (dp_status.ovf) begin
               status_in = ST_OVERFLOW;
               state_in  = S_EMIT;
            end else if (dp_status.through) begin
               cmd.op   = OP_SET_ORIGIN;
               state_in = S_DCHK;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_NSXY;
               state_in      = S_W1;
            end
         end
         S_W1: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_T1;
               state_in = S_M2;
            end
         end
         S_M2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_SXSY;
            state_in      = S_W2;
         end
         S_W2: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_NUM;
               state_in = S_M3;
            end
         end
         S_M3: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_NSXX;
            state_in      = S_W3;
         end
         S_W3: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_T1;
               state_in = S_M4;
            end
         end
         S_M4: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_SXSX;
            state_in      = S_W4;
         end
         S_W4: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_DEN;
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (dp_status.den_zero) begin
               status_in = ST_SLOPE_ZERO;
               state_in  = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DS_SLOPE;
               state_in      = S_WDS;
            end
         end
         S_WDS: begin
            if (dp_status.div_done) begin
               cmd.op   = OP_SET_SLOPE;
               state_in = dp_status.through ? S_PINIT : S_M5;
            end
         end
         S_M5: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_MSX;
            state_in      = S_W5;
         end
         S_W5: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_T1;
               state_in = S_D2;
            end
         end
         S_D2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DS_ICPT;
            state_in      = S_WD2;
         end
         S_WD2: begin
            if (dp_status.div_done) begin
               cmd.op   = OP_SET_ICPT;
               state_in = S_D3;
            end
         end
         S_D3: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DS_AVG;
            state_in      = S_WD3;
         end
         S_WD3: begin
            if (dp_status.div_done) begin
               cmd.op   = OP_SET_AVG;
               state_in = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.op   = OP_PASS_INIT;
            state_in = S_PRD;
         end
         S_PRD: begin
            state_in = S_PM;
         end
         S_PM: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_MXI;
            state_in      = S_PW1;
         end
         S_PW1: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_SET_YH;
               state_in = S_PM2;
            end
         end
         S_PM2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = dp_status.through ? MS_YHYH : MS_RR;
            state_in      = S_PW2;
         end
         S_PW2: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_ACC_A;
               state_in = S_PM3;
            end
         end
         S_PM3: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = dp_status.through ? MS_YIYI : MS_DD;
            state_in      = S_PW3;
         end
         S_PW3: begin
            if (dp_status.mul_done) begin
               cmd.op   = OP_ACC_C;
               state_in = dp_status.pass_last ? S_R2CHK : S_PRD;
            end
         end
         S_R2CHK: begin
            if (dp_status.c_zero) begin
               status_in = ST_R2_ZERO;
               state_in  = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DS_R2;
               state_in      = S_WD4;
            end
         end
         S_WD4: begin
            if (dp_status.div_done) begin
               cmd.op    = OP_SET_R2;
               status_in = ST_OK;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         status_ff <= status_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/linear_regression_fit.sv */
// ----------------------------------------------------------------------------
// linear_regression_fit
// Least-squares line fit with R squared over one segment of Q16.16 points.
//
//   channel   ports                                   transfer at edge with
//   --------  --------------------------------------  ---------------------
//   request   req_x_sample req_y_sample req_last_point start && !busy
//   response  rsp_intercept rsp_slope_value ...       rsp_strobe (1 cycle)
//   csr       csr_write_data (through_origin)         csr_write_enable
//
// A stored point keeps busy high for two multiplies on the shared six-step
// multiplier, so the next transfer waits for both. A dropped point (segment
// full) issues no multiply. Closing a segment adds a residual pass of three
// multiplies per stored point, the fit multiplies, up to four divides in the
// 128-bit bit-serial divider, and the emit.
// Synchronous reset clears the sums, the point count and through_origin.
// The response cannot be stalled; busy stays high until the strobe cycle.
// ----------------------------------------------------------------------------
module linear_regression_fit #(
   parameter int MAX_POINTS = lrf_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_x_sample,
   input  logic signed [31:0]  req_y_sample,
   input  logic                req_last_point,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_intercept,
   output logic signed [31:0]  rsp_slope_value,
   output logic [16:0]         rsp_r_squared,
   output logic [10:0]         rsp_point_count,
   output logic [1:0]          rsp_status
);

   import lrf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   lrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   lrf_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_x_sample     (req_x_sample),
      .req_y_sample     (req_y_sample),
      .req_last_point   (req_last_point),
      .rsp_strobe       (rsp_strobe),
      .rsp_intercept    (rsp_intercept),
      .rsp_slope_value  (rsp_slope_value),
      .rsp_r_squared    (rsp_r_squared),
      .rsp_point_count  (rsp_point_count),
      .rsp_status       (rsp_status)
   );

endmodule
